FILE: rtl/thmdc_pkg.sv
// Types, constants and code conversions for the thermal mode and door controller.
// Used by every module in rtl/; depends on nothing.
package thmdc_pkg;

  localparam int TEMP_W  = 12;
  localparam int ECHO_W  = 13;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;
  localparam int ANGLE_W = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_VENT_ON     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VENT_OFF    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ALARM       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OPEN_ECHO   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_ECHO  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_DELAY = 3'd5;

  localparam logic signed [TEMP_W-1:0] VENT_ON_RESET  = 12'sd350;
  localparam logic signed [TEMP_W-1:0] VENT_OFF_RESET = 12'sd300;
  localparam logic signed [TEMP_W-1:0] ALARM_RESET    = 12'sd400;
  localparam logic [ECHO_W-1:0]  OPEN_ECHO_RESET   = 13'd2900;
  localparam logic [ECHO_W-1:0]  CLOSE_ECHO_RESET  = 13'd4060;
  localparam logic [DELAY_W-1:0] CLOSE_DELAY_RESET = 16'd5000;
  localparam logic signed [TEMP_W-1:0] TEMP_RESET = 12'sd250;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TEMP   = 1'b1;

  localparam logic [1:0] SYS_CODE_NORMAL = 2'd0;
  localparam logic [1:0] SYS_CODE_VENT   = 2'd1;
  localparam logic [1:0] SYS_CODE_ALARM  = 2'd2;
  localparam logic [1:0] SYS_CODE_FAULT  = 2'd3;

  localparam logic [1:0] DOOR_CODE_CLOSED  = 2'd0;
  localparam logic [1:0] DOOR_CODE_OPEN    = 2'd1;
  localparam logic [1:0] DOOR_CODE_CLOSING = 2'd2;

  localparam logic [ANGLE_W-1:0] ANGLE_CLOSED = 7'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_OPEN   = 7'd90;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_VENT   = 4'b0010,
    MODE_ALARM  = 4'b0100,
    MODE_FAULT  = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    DOOR_CLOSED  = 3'b001,
    DOOR_OPEN    = 3'b010,
    DOOR_CLOSING = 3'b100
  } door_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] vent_on_tenths;
    logic signed [TEMP_W-1:0] vent_off_tenths;
    logic signed [TEMP_W-1:0] alarm_tenths;
    logic [ECHO_W-1:0]        open_echo_us;
    logic [ECHO_W-1:0]        close_echo_us;
    logic [DELAY_W-1:0]       close_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic                     opcode;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic                     temp_valid;
    logic                     motion;
    logic [ECHO_W-1:0]        echo_us;
    logic [TIME_W-1:0]        now_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         system_mode;
    logic [1:0]         door_mode;
    logic               led_red;
    logic               led_yellow;
    logic               led_green;
    logic [ANGLE_W-1:0] servo_angle;
    logic               servo_update;
    logic               buzzer_enable;
  } res_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_NORMAL: c = SYS_CODE_NORMAL;
      MODE_VENT:   c = SYS_CODE_VENT;
      MODE_ALARM:  c = SYS_CODE_ALARM;
      MODE_FAULT:  c = SYS_CODE_FAULT;
      default:     c = SYS_CODE_NORMAL;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] door_code(door_t d);
    logic [1:0] c;
    unique case (d)
      DOOR_CLOSED:  c = DOOR_CODE_CLOSED;
      DOOR_OPEN:    c = DOOR_CODE_OPEN;
      DOOR_CLOSING: c = DOOR_CODE_CLOSING;
      default:      c = DOOR_CODE_CLOSED;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/thmdc_climate.sv
// Climate side: stored temperature, sensor fault flag and the four-mode machine.
// Depends on thmdc_pkg.
module thmdc_climate import thmdc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  cmd_t  cmd,
  input  logic  fire,
  output mode_t mode_next
);

  logic signed [TEMP_W-1:0] temp;
  logic                     fault;
  mode_t                    mode;

  always_comb begin
    mode_next = mode;
    if (fault) begin
      mode_next = MODE_FAULT;
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          if (temp >= cfg.alarm_tenths) mode_next = MODE_ALARM;
          else if (temp > cfg.vent_on_tenths) mode_next = MODE_VENT;
        end
        MODE_VENT: begin
          if (temp >= cfg.alarm_tenths) mode_next = MODE_ALARM;
          else if (temp < cfg.vent_off_tenths) mode_next = MODE_NORMAL;
        end
        MODE_ALARM: begin
          if (temp < cfg.vent_off_tenths) mode_next = MODE_NORMAL;
        end
        default: mode_next = MODE_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp  <= TEMP_RESET;
      fault <= 1'b0;
      mode  <= MODE_NORMAL;
    end else if (fire) begin
      if (cmd.opcode == OP_TEMP) begin
        if (cmd.temp_valid) begin
          temp  <= cmd.temp_tenths;
          fault <= 1'b0;
        end else begin
          fault <= 1'b1;
        end
      end else begin
        mode <= mode_next;
      end
    end
  end

endmodule

FILE: rtl/thmdc_door.sv
// Door side: three-state door machine with wrapping-time close delay.
// Depends on thmdc_pkg; takes the climate mode of the same update.
module thmdc_door import thmdc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  cmd_t  cmd,
  input  logic  step,
  input  mode_t mode_next,
  output door_t door_next,
  output logic  changed
);

  door_t             door;
  logic [TIME_W-1:0] close_start;
  logic [TIME_W-1:0] close_start_next;
  logic [TIME_W-1:0] elapsed;
  logic              near;
  logic              clear;
  logic              expired;

  assign near    = cmd.motion && (cmd.echo_us != '0) && (cmd.echo_us <= cfg.open_echo_us);
  assign clear   = (cmd.echo_us == '0) || (cmd.echo_us >= cfg.close_echo_us);
  assign elapsed = cmd.now_ms - close_start;
  assign expired = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.close_delay_ms};

  always_comb begin
    door_next        = door;
    close_start_next = close_start;
    if (mode_next == MODE_ALARM || mode_next == MODE_FAULT) begin
      door_next = DOOR_CLOSED;
    end else begin
      unique case (door)
        DOOR_CLOSED: begin
          if (near) door_next = DOOR_OPEN;
        end
        DOOR_OPEN: begin
          if (clear) begin
            door_next        = DOOR_CLOSING;
            close_start_next = cmd.now_ms;
          end
        end
        DOOR_CLOSING: begin
          if (near) door_next = DOOR_OPEN;
          else if (expired) door_next = DOOR_CLOSED;
        end
        default: door_next = DOOR_CLOSED;
      endcase
    end
  end

  assign changed = door_next != door;

  always_ff @(posedge clk) begin
    if (rst) begin
      door        <= DOOR_CLOSED;
      close_start <= '0;
    end else if (step) begin
      door        <= door_next;
      close_start <= close_start_next;
    end
  end

endmodule

FILE: rtl/thermal_mode_and_auto_door_controller.sv
// Thermal mode and automatic door controller. An accepted item reaches the input
// register, is handled in one pass of the climate and door logic, and an update
// item's result is registered into the result register as the item fires. One
// item is taken every cycle; the rate is set only by the result register, which
// stalls the input register while a result waits to be taken. Temperature items
// give no result and never stall. Depends on thmdc_pkg, thmdc_climate, thmdc_door.
module thermal_mode_and_auto_door_controller import thmdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  cmd_t  cmd_q;
  logic  cmd_q_valid;
  logic  fire;
  logic  step;
  mode_t mode_next;
  door_t door_next;
  logic  changed;
  res_t  res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vent_on_tenths  <= VENT_ON_RESET;
      cfg.vent_off_tenths <= VENT_OFF_RESET;
      cfg.alarm_tenths    <= ALARM_RESET;
      cfg.open_echo_us    <= OPEN_ECHO_RESET;
      cfg.close_echo_us   <= CLOSE_ECHO_RESET;
      cfg.close_delay_ms  <= CLOSE_DELAY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_VENT_ON:     cfg.vent_on_tenths  <= cfg_wdata[TEMP_W-1:0];
        REG_VENT_OFF:    cfg.vent_off_tenths <= cfg_wdata[TEMP_W-1:0];
        REG_ALARM:       cfg.alarm_tenths    <= cfg_wdata[TEMP_W-1:0];
        REG_OPEN_ECHO:   cfg.open_echo_us    <= cfg_wdata[ECHO_W-1:0];
        REG_CLOSE_ECHO:  cfg.close_echo_us   <= cfg_wdata[ECHO_W-1:0];
        REG_CLOSE_DELAY: cfg.close_delay_ms  <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign fire = cmd_q_valid && ((cmd_q.opcode == OP_TEMP) || !res_valid || res_ready);
  assign step = fire && (cmd_q.opcode == OP_UPDATE);
  assign cmd_ready = !cmd_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_ready) begin
      cmd_q_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

  thmdc_climate u_climate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_q),
    .fire      (fire),
    .mode_next (mode_next)
  );

  thmdc_door u_door (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_q),
    .step      (step),
    .mode_next (mode_next),
    .door_next (door_next),
    .changed   (changed)
  );

  always_comb begin
    res_next.system_mode   = mode_code(mode_next);
    res_next.door_mode     = door_code(door_next);
    res_next.led_red       = (mode_next == MODE_ALARM) || (mode_next == MODE_FAULT);
    res_next.led_yellow    = mode_next != MODE_NORMAL;
    res_next.led_green     = (mode_next == MODE_NORMAL) || (mode_next == MODE_FAULT);
    res_next.servo_angle   = (door_next == DOOR_CLOSED) ? ANGLE_CLOSED : ANGLE_OPEN;
    res_next.servo_update  = changed;
    res_next.buzzer_enable = (mode_next == MODE_ALARM) || (mode_next == MODE_FAULT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

endmodule
